// File: sv/sidt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sidt_pkg
// shared sizes, codes and controller/datapath handoff types for the
// string intern table
// ----------------------------------------------------------------------------
package sidt_pkg;

	localparam int MAX_STRING  = 256;
	localparam int STORE_BYTES = 4096;
	localparam int MAX_ENTRIES = 1024;
	localparam int BUCKETS     = 2048;

	localparam int SIDX_W = $clog2(MAX_STRING);
	localparam int LEN_W  = $clog2(MAX_STRING + 1);
	localparam int OFF_W  = $clog2(STORE_BYTES);
	localparam int PTR_W  = $clog2(STORE_BYTES + 1);
	localparam int ID_W   = $clog2(MAX_ENTRIES);
	localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);
	localparam int SLOT_W = $clog2(BUCKETS);
	localparam int BKT_W  = $clog2(MAX_ENTRIES + 1);

	localparam logic [31:0] FNV_BASIS = 32'h811C_9DC5;
	localparam logic [31:0] FNV_PRIME = 32'h0100_0193;

	typedef enum logic [2:0] {
		ST_OK     = 3'd0,
		ST_SEALED = 3'd1,
		ST_FULL   = 3'd2,
		ST_RANGE  = 3'd3,
		ST_LONG   = 3'd4
	} status_t;

	typedef enum logic [2:0] {
		EM_NONE,
		EM_ERR,
		EM_GET,
		EM_DUP,
		EM_NEW
	} emit_t;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_GET,
		S_ERR,
		S_FIN,
		S_PROBE,
		S_CMP_LEN,
		S_CMP_BYTE,
		S_DUP,
		S_CHECK,
		S_COPY,
		S_COMMIT
	} state_t;

	typedef struct packed {
		logic    acc_byte;
		logic    clr_stage;
		logic    ent_rd_lid;
		logic    ent_rd_idx;
		logic    bkt_rd_hash;
		logic    bkt_rd_next;
		logic    cmp_start;
		logic    cmp_next;
		logic    copy_start;
		logic    copy_wr;
		logic    commit;
		logic    clr_step;
		emit_t   emit;
		status_t err_code;
	} dp_cmd_t;

	typedef struct packed {
		logic sealed;
		logic ovf;
		logic lid_ok;
		logic bkt_empty;
		logic probe_last;
		logic len_eq;
		logic len_zero;
		logic byte_eq;
		logic j_last;
		logic full;
		logic clr_done;
		logic out_free;
	} dp_sts_t;

endpackage

// File: sv/sidt_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sidt_if
// request and response channels with valid/ready handshake
// ----------------------------------------------------------------------------
interface sidt_req_if;
	import sidt_pkg::*;
	logic              valid;
	logic              ready;
	logic              action;
	logic [7:0]        data_byte;
	logic              last_byte;
	logic              empty_string;
	logic [ID_W-1:0]   lookup_id;
	modport source (output valid, action, data_byte, last_byte, empty_string, lookup_id,
		input ready);
	modport sink (input valid, action, data_byte, last_byte, empty_string, lookup_id,
		output ready);
endinterface

interface sidt_rsp_if;
	import sidt_pkg::*;
	logic              valid;
	logic              ready;
	logic [2:0]        status;
	logic [ID_W-1:0]   entry_id;
	logic              was_duplicate;
	logic [OFF_W-1:0]  stored_offset;
	logic [LEN_W-1:0]  stored_length;
	logic [CNT_W-1:0]  entry_count;
	modport source (output valid, status, entry_id, was_duplicate, stored_offset,
		stored_length, entry_count, input ready);
	modport sink (input valid, status, entry_id, was_duplicate, stored_offset,
		stored_length, entry_count, output ready);
endinterface

// File: sv/sidt_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sidt_ctrl
// sequencer: staging, bucket probe, compare, copy and response issue
// ----------------------------------------------------------------------------
module sidt_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	input  logic             req_action,
	input  logic             req_last,
	input  logic             req_empty,
	output logic             req_ready,
	input  sidt_pkg::dp_sts_t sts,
	output sidt_pkg::dp_cmd_t cmd
);
	import sidt_pkg::*;

	state_t  state_q, state_d;
	status_t err_q, err_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			err_q   <= ST_OK;
		end else begin
			state_q <= state_d;
			err_q   <= err_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		err_d   = err_q;
		case (state_q)
			S_CLEAR: begin
				if (sts.clr_done) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (req_valid) begin
					if (req_action) begin
						if (sts.lid_ok) state_d = S_GET;
						else begin
							state_d = S_ERR;
							err_d   = ST_RANGE;
						end
					end else if (req_empty || req_last) begin
						state_d = S_FIN;
					end
				end
			end
			S_GET, S_ERR, S_DUP, S_COMMIT: begin
				if (sts.out_free) state_d = S_IDLE;
			end
			S_FIN: begin
				if (sts.sealed) begin
					state_d = S_ERR;
					err_d   = ST_SEALED;
				end else if (sts.ovf) begin
					state_d = S_ERR;
					err_d   = ST_LONG;
				end else begin
					state_d = S_PROBE;
				end
			end
			S_PROBE: begin
				if (sts.bkt_empty) state_d = S_CHECK;
				else state_d = S_CMP_LEN;
			end
			S_CMP_LEN, S_CMP_BYTE: begin
				if ((state_q == S_CMP_LEN && !sts.len_eq) ||
					(state_q == S_CMP_BYTE && !sts.byte_eq)) begin
					if (sts.probe_last) begin
						state_d = S_ERR;
						err_d   = ST_FULL;
					end else begin
						state_d = S_PROBE;
					end
				end else if ((state_q == S_CMP_LEN && sts.len_zero) ||
					(state_q == S_CMP_BYTE && sts.j_last)) begin
					state_d = S_DUP;
				end else begin
					state_d = S_CMP_BYTE;
				end
			end
			S_CHECK: begin
				if (sts.full) begin
					state_d = S_ERR;
					err_d   = ST_FULL;
				end else if (sts.len_zero) begin
					state_d = S_COMMIT;
				end else begin
					state_d = S_COPY;
				end
			end
			S_COPY: begin
				if (sts.j_last) state_d = S_COMMIT;
			end
			default: state_d = S_CLEAR;
		endcase
	end

	// commands
	always_comb begin
		cmd          = '0;
		cmd.emit     = EM_NONE;
		cmd.err_code = err_q;
		req_ready    = 1'b0;
		case (state_q)
			S_CLEAR: cmd.clr_step = 1'b1;
			S_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					if (req_action) cmd.ent_rd_lid = sts.lid_ok;
					else if (req_empty) cmd.clr_stage = 1'b1;
					else cmd.acc_byte = 1'b1;
				end
			end
			S_GET: if (sts.out_free) cmd.emit = EM_GET;
			S_ERR: if (sts.out_free) cmd.emit = EM_ERR;
			S_DUP: begin
				if (sts.out_free) begin
					cmd.emit      = EM_DUP;
					cmd.clr_stage = 1'b1;
				end
			end
			S_COMMIT: begin
				if (sts.out_free) begin
					cmd.emit      = EM_NEW;
					cmd.commit    = 1'b1;
					cmd.clr_stage = 1'b1;
				end
			end
			S_FIN: begin
				if (sts.sealed || sts.ovf) cmd.clr_stage = 1'b1;
				else cmd.bkt_rd_hash = 1'b1;
			end
			S_PROBE: if (!sts.bkt_empty) cmd.ent_rd_idx = 1'b1;
			S_CMP_LEN, S_CMP_BYTE: begin
				if ((state_q == S_CMP_LEN && !sts.len_eq) ||
					(state_q == S_CMP_BYTE && !sts.byte_eq)) begin
					if (sts.probe_last) cmd.clr_stage = 1'b1;
					else cmd.bkt_rd_next = 1'b1;
				end else if ((state_q == S_CMP_LEN && sts.len_zero) ||
					(state_q == S_CMP_BYTE && sts.j_last)) begin
					cmd.emit = EM_NONE;
				end else if (state_q == S_CMP_LEN) begin
					cmd.cmp_start = 1'b1;
				end else begin
					cmd.cmp_next = 1'b1;
				end
			end
			S_CHECK: begin
				if (sts.full) cmd.clr_stage = 1'b1;
				else if (!sts.len_zero) cmd.copy_start = 1'b1;
			end
			S_COPY: cmd.copy_wr = 1'b1;
			default: cmd.emit = EM_NONE;
		endcase
	end

endmodule

// File: sv/sidt_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sidt_dp
// hash, staging buffer, byte store, entry tables, bucket table, response reg
// ----------------------------------------------------------------------------
module sidt_dp (
	input  logic                       clk,
	input  logic                       arst_n,
	input  sidt_pkg::dp_cmd_t          cmd,
	output sidt_pkg::dp_sts_t          sts,
	input  logic                       cfg_we,
	input  logic                       cfg_wdata,
	input  logic [7:0]                 req_byte,
	input  logic [sidt_pkg::ID_W-1:0]  req_lid,
	input  logic                       rsp_ready,
	output logic                       rsp_valid,
	output logic [2:0]                 rsp_status,
	output logic [sidt_pkg::ID_W-1:0]  rsp_id,
	output logic                       rsp_dup,
	output logic [sidt_pkg::OFF_W-1:0] rsp_offset,
	output logic [sidt_pkg::LEN_W-1:0] rsp_length,
	output logic [sidt_pkg::CNT_W-1:0] rsp_count
);
	import sidt_pkg::*;

	logic [7:0]        stage_mem [MAX_STRING];
	logic [7:0]        store_mem [STORE_BYTES];
	logic [OFF_W-1:0]  start_mem [MAX_ENTRIES];
	logic [LEN_W-1:0]  len_mem   [MAX_ENTRIES];
	logic [BKT_W-1:0]  bkt_mem   [BUCKETS];

	logic              sealed_q, ovf_q, out_valid_q;
	logic [31:0]       hash_q;
	logic [LEN_W-1:0]  slen_q, j_q, j_nxt;
	logic [CNT_W-1:0]  count_q;
	logic [PTR_W-1:0]  bump_q;
	logic [SLOT_W-1:0] slot_q, slot_nxt, clr_q, probe_q, bkt_a;
	logic [ID_W-1:0]   idx_q, lid_q, ent_ra;
	logic [7:0]        stage_rd, store_rd;
	logic [OFF_W-1:0]  ent_start_rd, st_ra, st_wa;
	logic [LEN_W-1:0]  ent_len_rd;
	logic [BKT_W-1:0]  bkt_rd, bkt_wd;
	logic [31:0]       prod;
	logic [PTR_W:0]    end_ptr;

	assign prod     = (hash_q ^ {24'd0, req_byte}) * FNV_PRIME;
	assign slot_nxt = (slot_q == SLOT_W'(BUCKETS - 1)) ? '0 : slot_q + 1'b1;
	assign j_nxt    = (cmd.cmp_start || cmd.copy_start) ? '0 : j_q + 1'b1;
	assign st_ra    = ent_start_rd + OFF_W'(j_nxt);
	assign st_wa    = bump_q[OFF_W-1:0] + OFF_W'(j_q);
	assign ent_ra   = cmd.ent_rd_lid ? req_lid : ID_W'(bkt_rd - 1'b1);
	assign end_ptr  = {1'b0, bump_q} + (PTR_W + 1)'(slen_q);

	always_comb begin
		if (cmd.clr_step) bkt_a = clr_q;
		else if (cmd.commit) bkt_a = slot_q;
		else if (cmd.bkt_rd_hash) bkt_a = hash_q[SLOT_W-1:0];
		else bkt_a = slot_nxt;
		bkt_wd = cmd.clr_step ? '0 : BKT_W'(count_q + 1'b1);
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sealed_q <= 1'b0;
			ovf_q    <= 1'b0;
			hash_q   <= FNV_BASIS;
			slen_q   <= '0;
			count_q  <= '0;
			bump_q   <= '0;
			clr_q    <= '0;
			probe_q  <= '0;
			j_q      <= '0;
			slot_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) sealed_q <= cfg_wdata;
			if (cmd.clr_stage) begin
				slen_q <= '0;
				hash_q <= FNV_BASIS;
				ovf_q  <= 1'b0;
			end else if (cmd.acc_byte) begin
				if (slen_q < LEN_W'(MAX_STRING)) begin
					slen_q <= slen_q + 1'b1;
					hash_q <= prod;
				end else begin
					ovf_q <= 1'b1;
				end
			end
			if (cmd.clr_step) clr_q <= clr_q + 1'b1;
			if (cmd.bkt_rd_hash) begin
				slot_q  <= hash_q[SLOT_W-1:0];
				probe_q <= '0;
			end else if (cmd.bkt_rd_next) begin
				slot_q  <= slot_nxt;
				probe_q <= probe_q + 1'b1;
			end
			if (cmd.cmp_start || cmd.cmp_next || cmd.copy_start || cmd.copy_wr)
				j_q <= cmd.copy_wr ? j_q + 1'b1 : j_nxt;
			if (cmd.commit) begin
				count_q <= count_q + 1'b1;
				bump_q  <= bump_q + PTR_W'(slen_q);
			end
			if (cmd.emit != EM_NONE) out_valid_q <= 1'b1;
			else if (rsp_ready) out_valid_q <= 1'b0;
		end
	end

	// memories
	always_ff @(posedge clk) begin
		if (cmd.acc_byte && slen_q < LEN_W'(MAX_STRING))
			stage_mem[slen_q[SIDX_W-1:0]] <= req_byte;
		stage_rd <= stage_mem[j_nxt[SIDX_W-1:0]];
	end

	always_ff @(posedge clk) begin
		if (cmd.copy_wr) store_mem[st_wa] <= stage_rd;
		store_rd <= store_mem[st_ra];
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			start_mem[count_q[ID_W-1:0]] <= bump_q[OFF_W-1:0];
			len_mem[count_q[ID_W-1:0]]   <= slen_q;
		end
		if (cmd.ent_rd_lid || cmd.ent_rd_idx) begin
			ent_start_rd <= start_mem[ent_ra];
			ent_len_rd   <= len_mem[ent_ra];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.clr_step || cmd.commit) bkt_mem[bkt_a] <= bkt_wd;
		if (cmd.bkt_rd_hash || cmd.bkt_rd_next) bkt_rd <= bkt_mem[bkt_a];
	end

	always_ff @(posedge clk) begin
		if (cmd.ent_rd_lid) lid_q <= req_lid;
		if (cmd.ent_rd_idx) idx_q <= ent_ra;
	end

	// response register
	always_ff @(posedge clk) begin
		if (cmd.emit != EM_NONE) begin
			rsp_status <= ST_OK;
			rsp_id     <= '0;
			rsp_dup    <= 1'b0;
			rsp_offset <= '0;
			rsp_length <= '0;
			rsp_count  <= count_q;
			case (cmd.emit)
				EM_ERR: rsp_status <= cmd.err_code;
				EM_GET: begin
					rsp_id     <= lid_q;
					rsp_offset <= ent_start_rd;
					rsp_length <= ent_len_rd;
				end
				EM_DUP: begin
					rsp_id     <= idx_q;
					rsp_dup    <= 1'b1;
					rsp_offset <= ent_start_rd;
					rsp_length <= ent_len_rd;
				end
				EM_NEW: begin
					rsp_id     <= count_q[ID_W-1:0];
					rsp_offset <= bump_q[OFF_W-1:0];
					rsp_length <= slen_q;
					rsp_count  <= count_q + 1'b1;
				end
				default: rsp_status <= ST_OK;
			endcase
		end
	end

	assign rsp_valid = out_valid_q;

	always_comb begin
		sts            = '0;
		sts.sealed     = sealed_q;
		sts.ovf        = ovf_q;
		sts.lid_ok     = CNT_W'(req_lid) < count_q;
		sts.bkt_empty  = (bkt_rd == '0);
		sts.probe_last = (probe_q == SLOT_W'(BUCKETS - 1));
		sts.len_eq     = (ent_len_rd == slen_q);
		sts.len_zero   = (slen_q == '0);
		sts.byte_eq    = (store_rd == stage_rd);
		sts.j_last     = (LEN_W'(j_q + 1'b1) == slen_q);
		sts.full       = (count_q >= CNT_W'(MAX_ENTRIES)) ||
			((CNT_W + 1)'(count_q) >= (CNT_W + 1)'(BUCKETS)) ||
			(end_ptr > (PTR_W + 1)'(STORE_BYTES));
		sts.clr_done   = (clr_q == SLOT_W'(BUCKETS - 1));
		sts.out_free   = !out_valid_q || rsp_ready;
	end

endmodule

// File: sv/string_intern_dedup_table_core.sv
`timescale 1ns / 1ps
// a non-final add byte is taken in idle; a get reads the entry tables, then S_GET loads the
// response reg when free; end of add: fin, probe and compare per entry, check, copy, commit
// throughput: one transaction in flight; bytes stream at 1 per cycle, set by the staging write
// reset: async active low; a clearing pass over all 2048 buckets runs before requests are taken
// ----------------------------------------------------------------------------
// string_intern_dedup_table_core
// string intern table with fnv-1a hashing, linear probe dedup and bump store
// ----------------------------------------------------------------------------
module string_intern_dedup_table_core (
	input  logic         clk,
	input  logic         arst_n,
	sidt_req_if.sink     req,
	sidt_rsp_if.source   rsp,
	input  logic         cfg_we,
	input  logic         cfg_wdata
);
	import sidt_pkg::*;

	// command / status handoff between sequencer and datapath
	dp_cmd_t cmd;
	dp_sts_t sts;

	// sequencer: owns the state machine and the pending error code
	sidt_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req.valid),
		.req_action (req.action),
		.req_last   (req.last_byte),
		.req_empty  (req.empty_string),
		.req_ready  (req.ready),
		.sts        (sts),
		.cmd        (cmd)
	);

	// datapath: hash, memories, counters and the response register
	sidt_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.req_byte   (req.data_byte),
		.req_lid    (req.lookup_id),
		.rsp_ready  (rsp.ready),
		.rsp_valid  (rsp.valid),
		.rsp_status (rsp.status),
		.rsp_id     (rsp.entry_id),
		.rsp_dup    (rsp.was_duplicate),
		.rsp_offset (rsp.stored_offset),
		.rsp_length (rsp.stored_length),
		.rsp_count  (rsp.entry_count)
	);

`ifndef SYNTHESIS
	// a response is only loaded when the output register can take it
	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit != EM_NONE) |-> sts.out_free)
		else $error("response loaded over a pending one");

	// no request transaction while the bucket table is being cleared
	a_no_req_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready) |-> !cmd.clr_step)
		else $error("request taken during clearing pass");

	// a new entry is never committed into a full table or store
	a_commit_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> !sts.full)
		else $error("commit with no room");
`endif

endmodule
